// ===== hw/rtl/ecdp_pkg.sv =====
// ----------------------------------------------------------------------------
// ecdp_pkg
// Shared constants and types for the event count and duration profiler.
// ----------------------------------------------------------------------------
package ecdp_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int USED_W      = $clog2(TABLE_DEPTH + 1);
  localparam int ID_W        = 11;
  localparam int CNT_W       = 32;
  localparam int TIME_W      = 48;
  localparam int WORD_W      = ID_W + CNT_W + TIME_W;

  localparam int S_DATA_W    = 64;
  localparam int S_USER_W    = 3;
  localparam int M_DATA_W    = 96;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_STOP   = 2'd1,
    CMD_REPORT = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [TIME_W-1:0] time_ns;
    logic [CNT_W-1:0]  count;
    logic [ID_W-1:0]   id;
  } slot_t;

endpackage

// ===== hw/rtl/event_count_duration_profiler_core.sv =====
// ----------------------------------------------------------------------------
// event_count_duration_profiler_core
// Per-ID entry counter and entry-to-exit time accumulator with sorted report.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one command per transfer. tuser carries cmd and
//   at_entry, tdata carries event_id and timestamp_ns. Session start and stop
//   events produce nothing; a report produces one item per table entry,
//   highest count first, ties in insertion order, or a single invalid item
//   with tlast when the table is empty.
//   Output stream (m_*): report items, tuser = valid_res, tlast = last.
//   The user must write attach_mode through cfg_we/cfg_wdata only while idle; not enforced.
// Sequence:
//   Slot state lives in one table RAM with a registered read and a separate write port.
//   Entry stop: linear ID search over the slots in use, else a new slot.
//   Exit stop: no search; the slot index is kept from the entry.
//   Report: a full table scan per emitted item.
//   s_tready is high only while no command is in progress.
// Reset: table empty, not inside a call, attach_mode 0. Table RAM not cleared.
// Stall: the output register holds an item until taken; the scan for the
//   next item runs meanwhile, and only its emit waits for the register.
// ----------------------------------------------------------------------------
module event_count_duration_profiler_core
  import ecdp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // event_id[10:0], timestamp_ns[58:11], zero pad
  input  logic [S_USER_W-1:0] s_tuser,   // cmd[1:0], at_entry[2]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // out_id[10:0], out_count[42:11], out_time_ns[90:43]
  output logic                m_tuser,   // valid_res
  output logic                m_tlast
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_E_RD, ST_E_CMP, ST_E_NEW, ST_X_RD, ST_X_CMP, ST_R_RD, ST_R_EMIT
  } state_t;

  state_t              state;
  logic                attach_mode;
  logic [USED_W-1:0]   slots_used;
  logic                inside_call;
  logic                first_pending;
  logic                pend_ok;
  logic [IDX_W-1:0]    pend_slot;
  logic [TIME_W-1:0]   entry_time;
  logic [TIME_W-1:0]   cur_ts;
  logic [ID_W-1:0]     cur_id;
  logic [IDX_W-1:0]    addr;
  logic [IDX_W-1:0]    rank;
  logic                scan_first;
  logic [CNT_W-1:0]    last_cnt;
  logic [IDX_W-1:0]    last_idx;
  logic                best_ok;
  slot_t               best;
  logic [IDX_W-1:0]    best_idx;
  logic                r_cmp;
  logic                r_cmp_phase;

  slot_t               mem [TABLE_DEPTH];
  slot_t               rd_q;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  slot_t               mem_wdata;

  logic [1:0]          in_cmd;
  logic                in_at_entry;
  logic [ID_W-1:0]     in_id;
  logic [TIME_W-1:0]   in_ts;
  logic                out_free;
  logic                addr_more;
  logic                eligible;
  logic [TIME_W-1:0]   delta;
  logic [TIME_W:0]     tsum;
  logic [CNT_W-1:0]    cnt_inc;

  assign in_cmd      = s_tuser[1:0];
  assign in_at_entry = s_tuser[2];
  assign in_id       = s_tdata[ID_W-1:0];
  assign in_ts       = s_tdata[ID_W+TIME_W-1:ID_W];
  assign s_tready    = (state == ST_IDLE);
  assign out_free    = !m_tvalid || m_tready;
  assign addr_more   = ({1'b0, addr} + USED_W'(1)) < slots_used;
  assign delta       = cur_ts - entry_time;
  assign tsum        = {1'b0, rd_q.time_ns} + {1'b0, delta};
  assign cnt_inc     = (&rd_q.count) ? rd_q.count : rd_q.count + CNT_W'(1);
  assign eligible    = scan_first || (rd_q.count < last_cnt) ||
                       ((rd_q.count == last_cnt) && (addr > last_idx));
  assign r_cmp       = (state == ST_R_RD) && r_cmp_phase;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = rd_q;
    unique case (state)
      ST_E_CMP: begin
        if (rd_q.id == cur_id) begin
          mem_we          = 1'b1;
          mem_wdata.count = cnt_inc;
        end
      end
      ST_E_NEW: begin
        if (slots_used < USED_W'(TABLE_DEPTH)) begin
          mem_we            = 1'b1;
          mem_waddr         = slots_used[IDX_W-1:0];
          mem_wdata.id      = cur_id;
          mem_wdata.count   = CNT_W'(1);
          mem_wdata.time_ns = '0;
        end
      end
      ST_X_CMP: begin
        mem_we            = 1'b1;
        mem_wdata.time_ns = tsum[TIME_W] ? {TIME_W{1'b1}} : tsum[TIME_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      attach_mode   <= 1'b0;
      slots_used    <= '0;
      inside_call   <= 1'b0;
      first_pending <= 1'b0;
      pend_ok       <= 1'b0;
      entry_time    <= '0;
      m_tvalid      <= 1'b0;
      r_cmp_phase   <= 1'b0;
    end else begin
      if (cfg_we) begin
        attach_mode <= cfg_wdata;
      end
      if ((state == ST_R_EMIT) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            case (in_cmd)
              CMD_START: begin
                slots_used    <= '0;
                inside_call   <= 1'b0;
                first_pending <= attach_mode;
                pend_ok       <= 1'b0;
                entry_time    <= '0;
              end
              CMD_STOP: begin
                if (first_pending) begin
                  first_pending <= 1'b0;
                end
                if (!first_pending || in_at_entry) begin
                  if (!inside_call) begin
                    inside_call <= 1'b1;
                    entry_time  <= in_ts;
                    cur_id      <= in_id;
                    addr        <= '0;
                    state       <= (slots_used == '0) ? ST_E_NEW : ST_E_RD;
                  end else begin
                    inside_call <= 1'b0;
                    if (pend_ok) begin
                      cur_ts <= in_ts;
                      addr   <= pend_slot;
                      state  <= ST_X_RD;
                    end
                  end
                end
              end
              CMD_REPORT: begin
                addr        <= '0;
                rank        <= '0;
                scan_first  <= 1'b1;
                best_ok     <= 1'b0;
                r_cmp_phase <= 1'b0;
                state       <= (slots_used == '0) ? ST_R_EMIT : ST_R_RD;
              end
              default: ;
            endcase
          end
        end
        ST_E_RD: state <= ST_E_CMP;
        ST_E_CMP: begin
          if (rd_q.id == cur_id) begin
            pend_ok   <= !cur_id[ID_W-1];
            pend_slot <= addr;
            state     <= ST_IDLE;
          end else if (addr_more) begin
            addr  <= addr + IDX_W'(1);
            state <= ST_E_RD;
          end else begin
            state <= ST_E_NEW;
          end
        end
        ST_E_NEW: begin
          if (slots_used < USED_W'(TABLE_DEPTH)) begin
            slots_used <= slots_used + USED_W'(1);
            pend_slot  <= slots_used[IDX_W-1:0];
            pend_ok    <= !cur_id[ID_W-1];
          end else begin
            pend_ok <= 1'b0;
          end
          state <= ST_IDLE;
        end
        ST_X_RD:  state <= ST_X_CMP;
        ST_X_CMP: state <= ST_IDLE;
        ST_R_RD: begin
          r_cmp_phase <= !r_cmp_phase;
          if (r_cmp) begin
            if (eligible && (!best_ok || rd_q.count > best.count)) begin
              best_ok  <= 1'b1;
              best     <= rd_q;
              best_idx <= addr;
            end
            if (addr_more) begin
              addr <= addr + IDX_W'(1);
            end else begin
              state <= ST_R_EMIT;
            end
          end
        end
        ST_R_EMIT: begin
          if (out_free) begin
            m_tuser  <= best_ok;
            m_tdata  <= best_ok ? M_DATA_W'({best.time_ns, best.count, best.id}) : '0;
            m_tlast  <= !best_ok || ({1'b0, rank} == slots_used - USED_W'(1));
            if (!best_ok || ({1'b0, rank} == slots_used - USED_W'(1))) begin
              state <= ST_IDLE;
            end else begin
              rank        <= rank + IDX_W'(1);
              last_cnt    <= best.count;
              last_idx    <= best_idx;
              scan_first  <= 1'b0;
              best_ok     <= 1'b0;
              addr        <= '0;
              r_cmp_phase <= 1'b0;
              state       <= ST_R_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/ecdp_checker.sv =====
// ----------------------------------------------------------------------------
// ecdp_checker
// Port-level checks for the profiler core, bound to the core module.
// ----------------------------------------------------------------------------
module ecdp_checker
  import ecdp_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata,
  input logic                m_tuser,
  input logic                m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed under stall");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast)
    else $error("invalid report item not last");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("invalid report item carries data");

  a_busy_report: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input ready in the middle of a report");

endmodule

bind event_count_duration_profiler_core ecdp_checker u_ecdp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
